// File: sv/gda_pkg.sv
package gda_pkg;

  localparam int DAY_W  = 5;
  localparam int MON_W  = 4;
  localparam int YEAR_W = 14;
  localparam int ADD_W  = 15;
  localparam int ACC_W  = 16;
  localparam int YEXT_W = YEAR_W + 1;
  localparam int CYC_W  = 9;

  localparam logic [ACC_W-1:0] LEAP_CYCLE  = ACC_W'(400);
  localparam logic [CYC_W-1:0] CYC_LAST    = CYC_W'(399);
  localparam logic [CYC_W-1:0] CENTURY_1   = CYC_W'(100);
  localparam logic [CYC_W-1:0] CENTURY_2   = CYC_W'(200);
  localparam logic [CYC_W-1:0] CENTURY_3   = CYC_W'(300);
  localparam logic [MON_W-1:0] MON_JAN     = MON_W'(1);
  localparam logic [MON_W-1:0] MON_DEC     = MON_W'(12);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_DOY,
    ST_WALK,
    ST_DONE
  } state_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    logic start;
    logic taken;
    logic mod_done;
    logic doy_done;
    logic walk_done;
  } status_t;

  typedef struct packed {
    logic in_mod;
    logic in_doy;
    logic in_walk;
    logic load;
    logic mod_step;
    logic mod_end;
    logic doy_step;
    logic doy_end;
    logic walk_step;
    logic walk_end;
    logic ready;
    logic valid;
  } ctrl_t;

  // position in the 400-year cycle
  function automatic logic is_leap(logic [CYC_W-1:0] r);
    return (r[1:0] == 2'd0) && (r != CENTURY_1) && (r != CENTURY_2) && (r != CENTURY_3);
  endfunction

  function automatic logic [DAY_W-1:0] month_len(logic [MON_W-1:0] m, logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DAY_W'(31);
      4'd4, 4'd6, 4'd9, 4'd11:                    len = DAY_W'(30);
      4'd2:                                       len = leap ? DAY_W'(29) : DAY_W'(28);
      default:                                    len = '0;
    endcase
    return len;
  endfunction

endpackage

// File: sv/gda_if.sv
interface gda_req_if;
  logic                        valid;
  logic                        ready;
  logic [gda_pkg::DAY_W-1:0]  start_day;
  logic [gda_pkg::MON_W-1:0]  start_month;
  logic [gda_pkg::YEAR_W-1:0] start_year;
  logic [gda_pkg::ADD_W-1:0]  add_days;

  modport source (output valid, start_day, start_month, start_year, add_days, input ready);
  modport sink   (input valid, start_day, start_month, start_year, add_days, output ready);
endinterface

interface gda_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [gda_pkg::DAY_W-1:0]  result_day;
  logic [gda_pkg::MON_W-1:0]  result_month;
  logic [gda_pkg::YEAR_W-1:0] result_year;

  modport source (output valid, result_day, result_month, result_year, input ready);
  modport sink   (input valid, result_day, result_month, result_year, output ready);
endinterface

// File: sv/gda_alu.sv
module gda_alu (
  input  gda_pkg::alu_op_t           op,
  input  logic [gda_pkg::ACC_W-1:0]  a,
  input  logic [gda_pkg::ACC_W-1:0]  b,
  output logic [gda_pkg::ACC_W-1:0]  y,
  output logic                       borrow,
  output logic                       zero
);
  import gda_pkg::*;

  logic [ACC_W:0] sum;

  always_comb begin
    unique case (op)
      ALU_ADD: sum = {1'b0, a} + {1'b0, b};
      ALU_SUB: sum = {1'b0, a} - {1'b0, b};
    endcase
  end

  assign y      = sum[ACC_W-1:0];
  assign borrow = (op == ALU_SUB) && sum[ACC_W];
  assign zero   = (y == '0);

endmodule

// File: sv/gda_ctrl.sv
module gda_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  gda_pkg::status_t status,
  output gda_pkg::ctrl_t   ctrl
);
  import gda_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctrl       = '0;
    unique case (state)
      ST_IDLE: begin
        ctrl.ready = 1'b1;
        if (status.start) begin
          ctrl.load  = 1'b1;
          state_next = ST_MOD;
        end
      end
      ST_MOD: begin
        ctrl.in_mod = 1'b1;
        if (status.mod_done) begin
          ctrl.mod_end = 1'b1;
          state_next   = ST_DOY;
        end else begin
          ctrl.mod_step = 1'b1;
        end
      end
      ST_DOY: begin
        ctrl.in_doy = 1'b1;
        if (status.doy_done) begin
          ctrl.doy_end = 1'b1;
          state_next   = ST_WALK;
        end else begin
          ctrl.doy_step = 1'b1;
        end
      end
      ST_WALK: begin
        ctrl.in_walk = 1'b1;
        if (status.walk_done) begin
          ctrl.walk_end = 1'b1;
          state_next    = ST_DONE;
        end else begin
          ctrl.walk_step = 1'b1;
        end
      end
      ST_DONE: begin
        ctrl.valid = 1'b1;
        if (status.taken) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// File: sv/gregorian_date_add_days_unit.sv
// Steps: the year is reduced modulo 400, the start day of the year is added to add_days, and
// whole months are then walked off from January until the day is found.
// Throughput: one item at a time; the next item can be taken in the cycle after the result has left.
// Every cycle in the modulo, day-of-year and walk states is one pass through the shared 16-bit add/subtract unit.
// Reset clears the sequencer only; the unit is ready in the cycle after reset.
module gregorian_date_add_days_unit (
  input logic      clk,
  input logic      rst,
  gda_req_if.sink  req,
  gda_rsp_if.source rsp
);
  import gda_pkg::*;

  status_t status;
  ctrl_t   ctrl;

  logic [ACC_W-1:0]  acc;
  logic [MON_W-1:0]  m;
  logic [YEXT_W-1:0] year;
  logic [CYC_W-1:0]  r400;
  logic [DAY_W-1:0]  sday;
  logic [MON_W-1:0]  smon;
  logic [ADD_W-1:0]  sadd;
  logic [DAY_W-1:0]  rday;
  logic [MON_W-1:0]  rmon;
  logic [YEAR_W-1:0] ryear;

  alu_op_t          alu_op;
  logic [ACC_W-1:0] alu_b;
  logic [ACC_W-1:0] alu_y;
  logic             alu_borrow;
  logic             alu_zero;
  logic [DAY_W-1:0] len;

  assign len = month_len(m, is_leap(r400));

  always_comb begin
    alu_op = ALU_SUB;
    alu_b  = ACC_W'(len);
    if (ctrl.in_mod) begin
      alu_b = LEAP_CYCLE;
    end else if (ctrl.in_doy) begin
      alu_op = ALU_ADD;
      alu_b  = status.doy_done ? ACC_W'(sday) : ACC_W'(len);
    end
  end

  gda_alu u_alu (
    .op     (alu_op),
    .a      (acc),
    .b      (alu_b),
    .y      (alu_y),
    .borrow (alu_borrow),
    .zero   (alu_zero)
  );

  assign status.start     = req.valid;
  assign status.taken     = rsp.ready;
  assign status.mod_done  = alu_borrow;
  assign status.doy_done  = (m >= smon);
  assign status.walk_done = alu_borrow || alu_zero;

  gda_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      acc  <= ACC_W'(req.start_year);
      year <= YEXT_W'(req.start_year);
      sday <= req.start_day;
      smon <= req.start_month;
      sadd <= req.add_days;
    end
    if (ctrl.mod_step) begin
      acc <= alu_y;
    end
    if (ctrl.mod_end) begin
      r400 <= acc[CYC_W-1:0];
      acc  <= ACC_W'(sadd);
      m    <= MON_JAN;
    end
    if (ctrl.doy_step) begin
      acc <= alu_y;
      m   <= m + MON_W'(1);
    end
    if (ctrl.doy_end) begin
      acc <= alu_y;
      m   <= MON_JAN;
    end
    if (ctrl.walk_step) begin
      acc <= alu_y;
      if (m == MON_DEC) begin
        m    <= MON_JAN;
        year <= year + YEXT_W'(1);
        r400 <= (r400 == CYC_LAST) ? '0 : r400 + CYC_W'(1);
      end else begin
        m <= m + MON_W'(1);
      end
    end
    if (ctrl.walk_end) begin
      rday  <= acc[DAY_W-1:0];
      rmon  <= m;
      ryear <= year[YEAR_W-1:0];
    end
  end

  assign req.ready        = ctrl.ready;
  assign rsp.valid        = ctrl.valid;
  assign rsp.result_day   = rday;
  assign rsp.result_month = rmon;
  assign rsp.result_year  = ryear;

`ifndef SYNTH
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !req.ready) else $error("result pending while taking an item");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready) else $error("ready after accept");

  a_walk_month: assert property (@(posedge clk) disable iff (rst)
    ctrl.in_walk |-> (m >= MON_JAN && m <= MON_DEC)) else $error("month out of range");

  a_walk_cycle: assert property (@(posedge clk) disable iff (rst)
    ctrl.in_walk |-> (r400 <= CYC_LAST)) else $error("leap cycle position out of range");
`endif

endmodule

// File: tb/sv/tb_gregorian_date_add_days_unit.sv
`timescale 1ns / 1ps

module tb_gregorian_date_add_days_unit;
  import gda_pkg::*;

  localparam int NUM_DIRECTED = 22;
  localparam int NUM_RANDOM   = 480;
  localparam int IDLE_LIMIT   = 6000;
  localparam int DRAIN_CYCLES = 1300;

  typedef struct packed {
    logic [DAY_W-1:0]  day;
    logic [MON_W-1:0]  month;
    logic [YEAR_W-1:0] year;
  } date_t;

  typedef struct packed {
    logic [DAY_W-1:0]  day;
    logic [MON_W-1:0]  month;
    logic [YEAR_W-1:0] year;
    logic [ADD_W-1:0]  add;
    logic              known;
    logic [DAY_W-1:0]  want_day;
    logic [MON_W-1:0]  want_month;
    logic [YEAR_W-1:0] want_year;
  } vector_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic sink_ready = 1'b0;
  bit   calm = 1'b0;

  date_t pending_dates[$];
  int    errors = 0;
  int    items_sent = 0;
  int    results_checked = 0;
  int    leap_days_seen = 0;
  int    idle_cycles = 0;
  int    stall_left = 0;

  // day, month, year, add, known, then the expected date where known
  vector_t date_table [NUM_DIRECTED] = '{
    '{1,  1,  2000,  0,     1, 1,  1, 2000},
    '{31, 12, 1999,  1,     1, 1,  1, 2000},
    '{28, 2,  2000,  1,     1, 29, 2, 2000},
    '{28, 2,  1900,  1,     1, 1,  3, 1900},
    '{28, 2,  2004,  1,     1, 29, 2, 2004},
    '{28, 2,  2100,  1,     1, 1,  3, 2100},
    '{28, 2,  0,     1,     1, 29, 2, 0},
    '{28, 2,  16000, 1,     1, 29, 2, 16000},
    '{0,  0,  2023,  0,     1, 0,  1, 2023},
    '{0,  1,  5,     0,     1, 0,  1, 5},
    '{31, 0,  1,     0,     1, 31, 1, 1},
    '{31, 2,  2023,  0,     1, 3,  3, 2023},
    '{31, 4,  2023,  0,     1, 1,  5, 2023},
    '{31, 12, 16383, 1,     1, 1,  1, 0},
    '{1,  1,  1,     32767, 0, 0,  0, 0},
    '{31, 12, 9999,  32767, 0, 0,  0, 0},
    '{1,  13, 2001,  0,     0, 0,  0, 0},
    '{31, 15, 16383, 32767, 0, 0,  0, 0},
    '{15, 6,  2024,  365,   0, 0,  0, 0},
    '{29, 2,  2024,  1461,  0, 0,  0, 0},
    '{1,  3,  2000,  59,    0, 0,  0, 0},
    '{31, 8,  8192,  16384, 0, 0,  0, 0}
  };

  gda_req_if req ();
  gda_rsp_if rsp ();

  assign rsp.ready = sink_ready;

  gregorian_date_add_days_unit u_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always #1 clk = ~clk;

  function automatic int unsigned days_in_month(int unsigned y, int unsigned m);
    if (m > MON_DEC) return 0;
    if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
    if (m != 2) return 31;
    return (((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0) ? 29 : 28;
  endfunction

  function automatic date_t advance_date(vector_t v);
    int unsigned remain;
    int unsigned yr;
    int unsigned mon;
    date_t res;
    remain = v.day;
    yr = v.year;
    for (mon = 1; mon < v.month; mon++) remain += days_in_month(yr, mon);
    remain += v.add;
    mon = MON_JAN;
    while (remain > days_in_month(yr, mon)) begin
      remain -= days_in_month(yr, mon);
      mon++;
      if (mon > MON_DEC) begin
        mon = MON_JAN;
        yr++;
      end
    end
    res.day = DAY_W'(remain);
    res.month = MON_W'(mon);
    res.year = YEAR_W'(yr);
    return res;
  endfunction

  function automatic vector_t random_date_item();
    vector_t v;
    v = '0;
    // noise: any bit pattern, months past December and day zero included
    if ($urandom_range(0, 9) >= 8) begin
      v.day = DAY_W'($urandom);
      v.month = MON_W'($urandom);
      v.year = YEAR_W'($urandom);
      v.add = ADD_W'($urandom);
      return v;
    end
    if ($urandom_range(0, 3) == 0)
      v.year = YEAR_W'(100 * $urandom_range(1, 99) + $urandom_range(0, 4));
    else
      v.year = YEAR_W'($urandom_range(1, 9999));
    v.month = MON_W'($urandom_range(1, 12));
    if ($urandom_range(0, 3) == 0)
      v.day = DAY_W'(days_in_month(v.year, v.month));
    else
      v.day = DAY_W'($urandom_range(1, days_in_month(v.year, v.month)));
    case ($urandom_range(0, 2))
      0:       v.add = ADD_W'($urandom_range(0, 60));
      1:       v.add = ADD_W'($urandom_range(0, 1500));
      default: v.add = ADD_W'($urandom);
    endcase
    return v;
  endfunction

  function automatic int draw_wait();
    if (calm) return 0;
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 17);
  endfunction

  initial begin
    vector_t vec;
    date_t   want;
    int      gap;
    req.valid       <= 1'b0;
    req.start_day   <= '0;
    req.start_month <= '0;
    req.start_year  <= '0;
    req.add_days    <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < NUM_DIRECTED + NUM_RANDOM; i++) begin
      vec = (i < NUM_DIRECTED) ? date_table[i] : random_date_item();
      calm = (i >= 150 && i < 200) || (i >= 400 && i < 430);
      gap = draw_wait();
      if (gap > 0) begin
        req.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      req.valid       <= 1'b1;
      req.start_day   <= vec.day;
      req.start_month <= vec.month;
      req.start_year  <= vec.year;
      req.add_days    <= vec.add;
      do @(posedge clk); while (!req.ready);
      if (vec.known) begin
        want.day = vec.want_day;
        want.month = vec.want_month;
        want.year = vec.want_year;
      end else begin
        want = advance_date(vec);
      end
      pending_dates.push_back(want);
      items_sent++;
    end
    req.valid <= 1'b0;
    calm = 1'b0;
    while (pending_dates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d date items (%0d from the table, rest random), checked %0d results.",
             items_sent, NUM_DIRECTED, results_checked);
    $display("Results landing on 29 February: %0d; mismatches: %0d.",
             leap_days_seen, errors);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  always @(posedge clk) begin : result_side
    date_t want;
    int    n;
    if (rst) begin
      sink_ready <= 1'b0;
      stall_left <= 0;
    end else if (rsp.valid && sink_ready) begin
      if (pending_dates.size() == 0) begin
        $error("result with no date outstanding: %0d/%0d/%0d",
               rsp.result_day, rsp.result_month, rsp.result_year);
        errors++;
      end else begin
        want = pending_dates.pop_front();
        if (rsp.result_day !== want.day) begin
          $error("result_day: expected %0d, got %0d", want.day, rsp.result_day);
          errors++;
        end
        if (rsp.result_month !== want.month) begin
          $error("result_month: expected %0d, got %0d", want.month, rsp.result_month);
          errors++;
        end
        if (rsp.result_year !== want.year) begin
          $error("result_year: expected %0d, got %0d", want.year, rsp.result_year);
          errors++;
        end
        if (want.day == 29 && want.month == 2) leap_days_seen++;
        results_checked++;
      end
      n = draw_wait();
      stall_left <= n;
      sink_ready <= (n == 0);
    end else if (stall_left > 0) begin
      // stall counts only while a result is on offer
      if (rsp.valid) stall_left <= stall_left - 1;
    end else begin
      sink_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no item moved for %0d cycles.", IDLE_LIMIT);
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
